// File: sv/svm_pkg.sv
// Shared types and constants of the saturating voice mixer.
// Used by the channel interfaces and by the mixer top level; depends on nothing.
package svm_pkg;

    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 17;
    localparam int SAMPLE_W = 16;

    typedef logic [REQ_W-1:0]           t_req_type;
    typedef logic [ADDR_W-1:0]          t_address;
    typedef logic [LEN_W-1:0]           t_length;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Request codes carried in req_type.
    localparam t_req_type REQ_WRITE = 2'd0;
    localparam t_req_type REQ_PLAY  = 2'd1;
    localparam t_req_type REQ_TICK  = 2'd2;

    // Limits of the mix.
    localparam t_sample MIX_MAX = 16'sh7fff;
    localparam t_sample MIX_MIN = 16'sh8000;

endpackage

// File: sv/svm_req_if.sv
// Request channel of the saturating voice mixer: valid, ready and one request.
// Depends on svm_pkg.
interface svm_req_if;
    import svm_pkg::*;

    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_address  address;
    t_length   sound_length;
    t_sample   sample_value;

    modport source (
        output valid, req_type, address, sound_length, sample_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, address, sound_length, sample_value,
        output ready
    );
endinterface

// File: sv/svm_mix_if.sv
// Result channel of the saturating voice mixer: valid, ready and one stereo sample.
// Depends on svm_pkg.
interface svm_mix_if;
    import svm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample left_sample;
    t_sample right_sample;

    modport source (
        output valid, left_sample, right_sample,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample,
        output ready
    );
endinterface

// File: sv/svm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/saturating_voice_mixer.sv
// Saturating voice mixer top level: request decode, voice table, sequencer and mix output.
// Depends on svm_pkg, svm_req_if, svm_mix_if and svm_ram.
//
//  Channel  Dir  Payload                                          Beat when
//  i_req    in   req_type, address, sound_length, sample_value    valid && ready
//  o_mix    out  left_sample, right_sample (same value)           valid && ready
//
// One request is handled at a time; i_req.ready is high only while the sequencer is idle.
// A write passes through the shared address reducer, then writes the sample memory; a play
// passes through the reducer, then walks the voices for a free one. The reducer takes one step
// at SAMPLE_DEPTH 65536 or more, one more per bit that AW falls short of ADDR_W. A frame tick
// does one memory read and one saturating add per sounding voice. Reset clears the voice busy
// flags and the output valid; the sample memory is not cleared. A stalled o_mix holds only a
// finished mix: the next tick runs to its end and then waits for the output register to free.
module saturating_voice_mixer #(
    parameter int VOICE_COUNT  = 8,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    svm_req_if.sink   i_req,
    svm_mix_if.source o_mix
);
    import svm_pkg::*;

    // Memory address width and voice index width.
    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    // The reducer takes an address modulo SAMPLE_DEPTH by restoring subtraction of
    // SAMPLE_DEPTH shifted left by RED_LAST down to zero, one shift per cycle.
    localparam int RED_LAST = (AW >= ADDR_W) ? 0 : (ADDR_W - AW);
    localparam int KW       = (RED_LAST > 0) ? $clog2(RED_LAST + 1) : 1;
    localparam int RW       = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

    localparam logic [RW-1:0] DEPTH_W    = RW'(SAMPLE_DEPTH);
    localparam logic [AW-1:0] ADDR_LAST  = AW'(SAMPLE_DEPTH - 1);
    localparam logic [VW-1:0] VOICE_LAST = VW'(VOICE_COUNT - 1);
    localparam logic [KW-1:0] STEP_FIRST = KW'(RED_LAST);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_WRITE  = 3'd2;
    localparam logic [2:0] ST_PLAY   = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_ADD    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // Sequencer and request registers.
    logic [2:0]      r_state, n_state;
    t_req_type       r_kind, n_kind;
    logic [RW-1:0]   r_x, n_x;
    logic [KW-1:0]   r_step, n_step;
    logic [VW-1:0]   r_voice, n_voice;
    t_length         r_len_in, n_len_in;
    t_sample         r_val, n_val;
    t_sample         r_sum, n_sum;
    logic            r_out_valid, n_out_valid;
    t_sample         r_out_data, n_out_data;

    // Voice table. The current address stands in for start plus position, kept
    // already reduced modulo the memory depth.
    logic            r_busy [VOICE_COUNT];
    logic [AW-1:0]   r_cur  [VOICE_COUNT];
    t_length         r_len  [VOICE_COUNT];
    t_length         r_pos  [VOICE_COUNT];

    // Voice table updates issued by the sequencer for voice r_voice.
    logic            voice_claim;
    logic            voice_free;
    logic            voice_adv;

    // Sample memory port controls and the shared datapath.
    logic            ram_wr_en;
    logic            ram_rd_en;
    logic [SAMPLE_W-1:0] ram_rd_data;
    logic [RW-1:0]   red_sub;
    logic [SAMPLE_W:0] add_wide;
    t_sample         add_sat;
    logic            in_beat;
    logic            out_beat;

    assign in_beat  = i_req.valid && i_req.ready;
    assign out_beat = r_out_valid && o_mix.ready;

    // Shared reducer subtrahend and saturating adder.
    assign red_sub  = DEPTH_W << r_step;
    assign add_wide = {r_sum[SAMPLE_W-1], r_sum} + {ram_rd_data[SAMPLE_W-1], ram_rd_data};

    always_comb begin
        if (add_wide[SAMPLE_W] != add_wide[SAMPLE_W-1]) begin
            // The sign bit of the wide sum tells which way the addition overflowed.
            add_sat = add_wide[SAMPLE_W] ? MIX_MIN : MIX_MAX;
        end else begin
            add_sat = t_sample'(add_wide[SAMPLE_W-1:0]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_x         = r_x;
        n_step      = r_step;
        n_voice     = r_voice;
        n_len_in    = r_len_in;
        n_val       = r_val;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        voice_claim = 1'b0;
        voice_free  = 1'b0;
        voice_adv   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;

        if (out_beat) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_kind   = i_req.req_type;
                    n_x      = RW'(i_req.address);
                    n_len_in = i_req.sound_length;
                    n_val    = i_req.sample_value;
                    n_step   = STEP_FIRST;
                    n_voice  = '0;
                    n_sum    = '0;
                    if (i_req.req_type inside {REQ_WRITE, REQ_PLAY}) begin
                        n_state = ST_REDUCE;
                    end else if (i_req.req_type == REQ_TICK) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_REDUCE: begin
                if (r_x >= red_sub) begin
                    n_x = r_x - red_sub;
                end
                if (r_step == '0) begin
                    n_state = (r_kind == REQ_WRITE) ? ST_WRITE : ST_PLAY;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_WRITE: begin
                ram_wr_en = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_PLAY: begin
                // Walk the voices from the lowest index; with none free the request is dropped.
                if (!r_busy[r_voice]) begin
                    voice_claim = 1'b1;
                    n_state     = ST_IDLE;
                end else if (r_voice == VOICE_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_voice = r_voice + 1'b1;
                end
            end
            ST_CHECK: begin
                if (r_busy[r_voice] && (r_pos[r_voice] < r_len[r_voice])) begin
                    ram_rd_en = 1'b1;
                    voice_adv = 1'b1;
                    n_state   = ST_ADD;
                end else begin
                    // A finished voice is released here and adds nothing.
                    voice_free = r_busy[r_voice];
                    if (r_voice == VOICE_LAST) begin
                        n_state = ST_DONE;
                    end else begin
                        n_voice = r_voice + 1'b1;
                    end
                end
            end
            ST_ADD: begin
                n_sum = add_sat;
                if (r_voice == VOICE_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_voice = r_voice + 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_mix.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_sum;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_kind     <= n_kind;
        r_x        <= n_x;
        r_step     <= n_step;
        r_voice    <= n_voice;
        r_len_in   <= n_len_in;
        r_val      <= n_val;
        r_sum      <= n_sum;
        r_out_data <= n_out_data;
    end

    // Voice table: busy flags reset; the rest is loaded when a voice is claimed and stepped on each read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_busy[v] <= 1'b0;
            end
        end else if (voice_claim) begin
            r_busy[r_voice] <= 1'b1;
        end else if (voice_free) begin
            r_busy[r_voice] <= 1'b0;
        end
        if (voice_claim) begin
            r_cur[r_voice] <= r_x[AW-1:0];
            r_len[r_voice] <= r_len_in;
            r_pos[r_voice] <= '0;
        end else if (voice_adv) begin
            r_cur[r_voice] <= (r_cur[r_voice] == ADDR_LAST) ? '0 : r_cur[r_voice] + 1'b1;
            r_pos[r_voice] <= r_pos[r_voice] + 1'b1;
        end
    end

    svm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_x[AW-1:0]),
        .i_wr_data (r_val),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_cur[r_voice]),
        .o_rd_data (ram_rd_data)
    );

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_mix.valid        = r_out_valid;
    assign o_mix.left_sample  = r_out_data;
    assign o_mix.right_sample = r_out_data;

endmodule

// File: verif/saturating_voice_mixer_tb.sv
// Self-checking testbench for the saturating voice mixer: directed and random requests,
// with an in-bench predictor of the voice table and the saturating mix.
// Depends on svm_pkg, svm_req_if, svm_mix_if and the saturating_voice_mixer RTL.
module saturating_voice_mixer_tb;
    import svm_pkg::*;

    localparam int VOICE_COUNT  = 8;
    localparam int SAMPLE_DEPTH = 65536;

    // Two copies of the mixer state: one follows the stimulus as it is planned, the
    // other follows the beats that the block actually accepts.
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    localparam t_req_type REQ_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS   = 1300;     // requests planned in all, filler writes included
    localparam int HOT_BASE      = 'hffe0;   // small window of addresses that wraps at the top
    localparam int CALM_ITEMS    = 120;      // no idling once this few requests are left
    localparam int HOLD_AT       = 350;      // accepted requests before the long output stall
    localparam int HOLD_CYCLES   = 250;
    localparam int DRAIN_AT      = 900;      // requests sent before the sender waits for drain
    localparam int SETTLE_CYCLES = 40;       // longer than a full eight-voice frame tick
    localparam int MAX_REPORTS   = 10;
    localparam longint TIMEOUT_UNITS = 20_000_000;

    typedef struct packed {
        t_req_type kind;
        t_address  address;
        t_length   sound_length;
        t_sample   sample_value;
    } t_mix_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    svm_req_if req_ch ();
    svm_mix_if mix_ch ();

    saturating_voice_mixer #(
        .VOICE_COUNT  (VOICE_COUNT),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_mix   (mix_ch)
    );

    // Everything the bench drives comes from these registers, so each input is known from
    // time zero and changes only through nonblocking assignments at the rising edge.
    logic     req_valid_r = 1'b0;
    t_mix_req req_item_r  = '0;
    logic     mix_ready_r = 1'b0;
    logic     hold_off    = 1'b0;

    assign req_ch.valid        = req_valid_r;
    assign req_ch.req_type     = req_item_r.kind;
    assign req_ch.address      = req_item_r.address;
    assign req_ch.sound_length = req_item_r.sound_length;
    assign req_ch.sample_value = req_item_r.sample_value;
    assign mix_ch.ready        = mix_ready_r;

    // Mixer state, one copy per context.
    t_sample  sample_image [2][SAMPLE_DEPTH];
    t_address voice_base   [2][VOICE_COUNT];
    t_length  voice_len    [2][VOICE_COUNT];
    t_length  voice_pos    [2][VOICE_COUNT];
    bit       voice_on     [2][VOICE_COUNT];

    // Addresses that a planned write has filled. A frame tick is only planned once every
    // address it will read is in here, so the block never plays unwritten memory.
    bit addr_written [SAMPLE_DEPTH];

    t_mix_req pending_q [$];
    t_sample  expected_mix_q [$];

    int unsigned sent_count     = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned mixes_checked  = 0;
    int unsigned clamped_mixes  = 0;
    int unsigned writes_seen    = 0;
    int unsigned plays_started  = 0;
    int unsigned plays_dropped  = 0;
    int unsigned ticks_seen     = 0;
    int unsigned ignored_seen   = 0;
    int unsigned gap_left       = 0;
    int unsigned stall_left     = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one request to the chosen copy of the state. Returns 1 when the request is a
    // frame tick, with the saturated mix in mix_out.
    function automatic bit advance_mixer(input int ctx, input t_mix_req r,
                                         output t_sample mix_out);
        int          acc;
        int unsigned where;
        bit          claimed;
        bit          produced;
        acc      = 0;
        claimed  = 1'b0;
        produced = 1'b0;
        mix_out  = '0;
        case (r.kind)
            REQ_WRITE: begin
                sample_image[ctx][r.address] = r.sample_value;
                if (ctx == LIVE) writes_seen++;
            end
            REQ_PLAY: begin
                // The lowest free voice takes the sound; with none free it is lost.
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    if (!claimed && !voice_on[ctx][v]) begin
                        voice_base[ctx][v] = r.address;
                        voice_len[ctx][v]  = r.sound_length;
                        voice_pos[ctx][v]  = '0;
                        voice_on[ctx][v]   = 1'b1;
                        claimed            = 1'b1;
                    end
                end
                if (ctx == LIVE) begin
                    if (claimed) plays_started++;
                    else plays_dropped++;
                end
            end
            REQ_TICK: begin
                // Voices are summed in index order and the sum is clamped after every
                // addition, so the order of the voices can change the result.
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    if (voice_on[ctx][v]) begin
                        if (voice_pos[ctx][v] >= voice_len[ctx][v]) begin
                            voice_on[ctx][v] = 1'b0;
                        end else begin
                            where = (int'(voice_base[ctx][v]) + int'(voice_pos[ctx][v]))
                                    % SAMPLE_DEPTH;
                            acc = acc + int'(sample_image[ctx][where]);
                            if (acc > int'(MIX_MAX)) acc = int'(MIX_MAX);
                            if (acc < int'(MIX_MIN)) acc = int'(MIX_MIN);
                            voice_pos[ctx][v] = voice_pos[ctx][v] + 1'b1;
                        end
                    end
                end
                mix_out  = t_sample'(acc);
                produced = 1'b1;
                if (ctx == LIVE) ticks_seen++;
            end
            default: begin
                if (ctx == LIVE) ignored_seen++;
            end
        endcase
        return produced;
    endfunction

    function automatic t_mix_req make_req(input t_req_type kind, input t_address address,
                                          input t_length sound_length,
                                          input t_sample sample_value);
        t_mix_req r;
        r.kind         = kind;
        r.address      = address;
        r.sound_length = sound_length;
        r.sample_value = sample_value;
        return r;
    endfunction

    task automatic queue_request(input t_mix_req r);
        t_sample unused_mix;
        pending_q.push_back(r);
        if (r.kind == REQ_WRITE) addr_written[r.address] = 1'b1;
        void'(advance_mixer(PLAN, r, unused_mix));
    endtask

    // Plans a frame tick with junk in its unused fields. Any sample the tick is about to
    // read that was never written gets a random write first.
    task automatic queue_tick();
        int unsigned where;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            if (voice_on[PLAN][v] && voice_pos[PLAN][v] < voice_len[PLAN][v]) begin
                where = (int'(voice_base[PLAN][v]) + int'(voice_pos[PLAN][v])) % SAMPLE_DEPTH;
                if (!addr_written[where]) begin
                    queue_request(make_req(REQ_WRITE, t_address'(where), t_length'($urandom),
                                           t_sample'($urandom)));
                end
            end
        end
        queue_request(make_req(REQ_TICK, t_address'($urandom), t_length'($urandom),
                               t_sample'($urandom)));
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    endtask

    // Request driver. A beat that is accepted here is run through the live predictor, and a
    // new request is offered once the slot is free, unless an idle burst is under way, the
    // queue is empty, or the one-time drain pause is holding the sender back.
    always @(posedge i_clk) begin
        t_sample mix_val;
        bit      calm;
        calm = (pending_q.size() < CALM_ITEMS);
        if (!i_rst_n) begin
            req_valid_r <= 1'b0;
        end else begin
            if (req_valid_r && req_ch.ready) begin
                if (advance_mixer(LIVE, make_req(req_ch.req_type, req_ch.address,
                                                 req_ch.sound_length, req_ch.sample_value),
                                  mix_val)) begin
                    expected_mix_q.push_back(mix_val);
                end
                accepted_count++;
            end
            if (!req_valid_r || req_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_valid_r <= 1'b0;
                end else if (pending_q.size() == 0 ||
                             (sent_count == DRAIN_AT && expected_mix_q.size() != 0)) begin
                    req_valid_r <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < 15) begin
                    gap_left = $urandom_range(0, 3);
                    req_valid_r <= 1'b0;
                end else begin
                    req_item_r  <= pending_q.pop_front();
                    req_valid_r <= 1'b1;
                    sent_count++;
                end
            end
        end
    end

    // Mix monitor. Every accepted beat must match the oldest expected mix on both channels.
    // Ready drops in short random bursts, and for one long stretch while hold_off is set.
    always @(posedge i_clk) begin
        t_sample want;
        bit      calm;
        calm = (pending_q.size() < CALM_ITEMS);
        if (!i_rst_n) begin
            mix_ready_r <= 1'b0;
        end else begin
            if (mix_ch.valid && mix_ready_r) begin
                mixes_checked++;
                if (expected_mix_q.size() == 0) begin
                    flag_mismatch($sformatf("mix beat L=%0d R=%0d with nothing expected",
                                            mix_ch.left_sample, mix_ch.right_sample));
                end else begin
                    want = expected_mix_q.pop_front();
                    if (want == MIX_MAX || want == MIX_MIN) clamped_mixes++;
                    if (mix_ch.left_sample !== want) begin
                        flag_mismatch($sformatf("left sample expected %0d, got %0d",
                                                want, mix_ch.left_sample));
                    end
                    if (mix_ch.right_sample !== want) begin
                        flag_mismatch($sformatf("right sample expected %0d, got %0d",
                                                want, mix_ch.right_sample));
                    end
                end
            end
            if (hold_off) begin
                mix_ready_r <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                mix_ready_r <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 12) begin
                stall_left = $urandom_range(0, 3);
                mix_ready_r <= 1'b0;
            end else begin
                mix_ready_r <= 1'b1;
            end
        end
    end

    // Long output stall: the sender keeps offering, so a finished mix sits in the output
    // register, the next tick runs up to it, and the request side backs up.
    initial begin
        while (accepted_count < HOLD_AT) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned pick;
        bit          voice_free;
        t_address    addr;
        t_length     len;
        t_sample     val;

        // Directed part. Three samples straddle the top of memory so that sounds wrap.
        queue_tick();                                        // nothing playing: silence
        queue_request(make_req(REQ_WRITE, 16'hffff, '0, MIX_MAX));
        queue_request(make_req(REQ_WRITE, 16'h0000, '0, MIX_MIN));
        queue_request(make_req(REQ_WRITE, 16'h0001, '0, t_sample'(-1)));
        queue_request(make_req(REQ_PLAY, 16'hffff, 17'd3, '0));   // voice 0, wraps to zero
        queue_request(make_req(REQ_PLAY, 16'hffff, 17'd0, '0));   // voice 1, zero length
        queue_request(make_req(REQ_PLAY, 16'hffff, 17'd1, '0));   // voice 2
        queue_tick();                    // zero-length voice freed, top clamp reached
        queue_tick();                    // wrapped read of the most negative sample
        queue_request(make_req(REQ_PLAY, 16'h0000, 17'd2, '0));   // reuses freed voice 1
        queue_tick();                    // bottom clamp reached
        queue_request(make_req(REQ_UNUSED, 16'hffff, 17'h1ffff, t_sample'(16'hffff)));
        // Clamping after every addition: -1, then two full-scale positives that clamp,
        // then full-scale negative, gives -1 rather than the unclamped sum.
        queue_request(make_req(REQ_PLAY, 16'hffff, 17'd1, '0));
        queue_request(make_req(REQ_PLAY, 16'hffff, 17'd1, '0));
        queue_request(make_req(REQ_PLAY, 16'h0000, 17'd1, '0));
        queue_tick();
        // Fill the remaining voices, then a play that finds no free voice.
        for (int k = 0; k < 4; k++) begin
            queue_request(make_req(REQ_PLAY, t_address'($urandom), 17'd0, '0));
        end
        queue_request(make_req(REQ_PLAY, 16'h1234, 17'h1ffff, t_sample'($urandom)));
        queue_tick();                                        // every voice freed
        // Two sounds longer than the run keep two voices busy for good. They share one
        // start, so each tick needs only one fresh sample.
        queue_request(make_req(REQ_PLAY, 16'hc000, 17'h10000, '0));
        queue_request(make_req(REQ_PLAY, 16'hc000, 17'h1ffff, '0));
        queue_tick();

        // Random part: writes and plays aimed mostly at a small window, so that playing
        // sounds overlap and see their samples rewritten.
        while (pending_q.size() < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                addr = ($urandom_range(0, 99) < 60) ?
                       t_address'(HOT_BASE + $urandom_range(0, 63)) : t_address'($urandom);
                case ($urandom_range(0, 9))
                    0: val = MIX_MAX;
                    1: val = MIX_MIN;
                    2: val = '0;
                    3: val = t_sample'(-1);
                    default: val = t_sample'($urandom);
                endcase
                queue_request(make_req(REQ_WRITE, addr, t_length'($urandom), val));
            end else if (pick < 58) begin
                voice_free = 1'b0;
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    if (!voice_on[PLAN][v]) voice_free = 1'b1;
                end
                if (!voice_free) begin
                    // Dropped anyway, so any fields at all may go along.
                    queue_request(make_req(REQ_PLAY, t_address'($urandom),
                                           t_length'($urandom), t_sample'($urandom)));
                end else begin
                    addr = ($urandom_range(0, 99) < 70) ?
                           t_address'(HOT_BASE + $urandom_range(0, 63)) : t_address'($urandom);
                    len  = ($urandom_range(0, 99) < 80) ?
                           t_length'($urandom_range(0, 24)) : t_length'($urandom_range(25, 200));
                    queue_request(make_req(REQ_PLAY, addr, len, t_sample'($urandom)));
                end
            end else if (pick < 95) begin
                queue_tick();
            end else begin
                queue_request(make_req(REQ_UNUSED, t_address'($urandom), t_length'($urandom),
                                       t_sample'($urandom)));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_valid_r) @(posedge i_clk);
        while (expected_mix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d writes, %0d plays (%0d lost with every voice busy), %0d ticks, %0d ignored.",
                 writes_seen, plays_started + plays_dropped, plays_dropped, ticks_seen,
                 ignored_seen);
        $display("Checked %0d mixes, %0d of them at a clamp limit; %0d mismatches.",
                 mixes_checked, clamped_mixes, mismatch_count);
        if (mismatch_count == 0 && expected_mix_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
